>>> design/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// shared constants, codes and microcode table of the bounded set table
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int OP_W            = 2;
  localparam int VALUE_W         = 32;
  localparam int COUNT_W         = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_MEMBER = 2'd2;

  typedef logic [2:0] step_t;

  localparam step_t S_WAIT     = 3'd0;
  localparam step_t S_SCAN_RD  = 3'd1;
  localparam step_t S_SCAN_CMP = 3'd2;
  localparam step_t S_HIT      = 3'd3;
  localparam step_t S_SHIFT_RD = 3'd4;
  localparam step_t S_SHIFT_WR = 3'd5;
  localparam step_t S_MISS     = 3'd6;
  localparam step_t S_DONE     = 3'd7;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_REQ,
    C_IDX_END,
    C_MATCH,
    C_OP_DEL,
    C_RSP_FREE
  } cond_t;

  typedef enum logic [2:0] {
    A_LOAD,
    A_READ,
    A_CMP,
    A_HIT,
    A_READ_NEXT,
    A_SHIFT,
    A_MISS,
    A_RESPOND
  } act_t;

  typedef struct packed {
    cond_t cond;
    step_t jump_true;
    step_t jump_false;
    act_t  act;
  } uword_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_WAIT:     w = '{C_REQ,      S_SCAN_RD,  S_WAIT,     A_LOAD};
      S_SCAN_RD:  w = '{C_IDX_END,  S_MISS,     S_SCAN_CMP, A_READ};
      S_SCAN_CMP: w = '{C_MATCH,    S_HIT,      S_SCAN_RD,  A_CMP};
      S_HIT:      w = '{C_OP_DEL,   S_SHIFT_RD, S_DONE,     A_HIT};
      S_SHIFT_RD: w = '{C_IDX_END,  S_DONE,     S_SHIFT_WR, A_READ_NEXT};
      S_SHIFT_WR: w = '{C_ALWAYS,   S_SHIFT_RD, S_SHIFT_RD, A_SHIFT};
      S_MISS:     w = '{C_ALWAYS,   S_DONE,     S_DONE,     A_MISS};
      S_DONE:     w = '{C_RSP_FREE, S_WAIT,     S_DONE,     A_RESPOND};
      default:    w = '{C_ALWAYS,   S_WAIT,     S_WAIT,     A_READ};
    endcase
    return w;
  endfunction

endpackage

>>> design/bst_if.sv
// ----------------------------------------------------------------------------
// bst_req_if / bst_rsp_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bst_req_if;
  import bst_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface bst_rsp_if;
  import bst_pkg::*;
  logic               valid;
  logic               ready;
  logic               success;
  logic [COUNT_W-1:0] element_count;
  logic               set_empty;
  modport source (output valid, output success, output element_count, output set_empty,
                  input ready);
  modport sink (input valid, input success, input element_count, input set_empty,
                output ready);
endinterface

>>> design/bst_ram.sv
// ----------------------------------------------------------------------------
// bst_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/bounded_set_table_core.sv
// ----------------------------------------------------------------------------
// bounded_set_table_core
// operation: each request scans the stored entries in turn; a delete that hits
//   then moves every later entry down one place; the result is registered
// throughput: one request at a time, a new request is taken only once the
//   previous result is registered; scan and shift share the single ram read port
// reset: synchronous, empties the set; ram contents are left as they are
// ----------------------------------------------------------------------------
module bounded_set_table_core #(
  parameter int MAX_ENTRIES = bst_pkg::MAX_ENTRIES_DEF
) (
  input logic     clk,
  input logic     rst,
  bst_req_if.sink   req,
  bst_rsp_if.source rsp
);
  import bst_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  step_t               step;
  uword_t              uw;
  logic                cond_hit;
  logic [OP_W-1:0]     op;
  logic [VALUE_W-1:0]  val;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       idx_inc;
  logic [CW-1:0]       count;
  logic                ok;
  logic                not_full;
  logic                do_insert;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [VALUE_W-1:0]  wdata;
  logic [AW-1:0]       raddr;
  logic [VALUE_W-1:0]  rdata;
  logic                rsp_valid;

  assign uw        = ucode(step);
  assign idx_inc   = CW'(idx + 1'b1);
  assign not_full  = count < CW'(MAX_ENTRIES);
  assign do_insert = (op == OP_INSERT) && not_full;

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_REQ:      cond_hit = req.valid;
      C_IDX_END:  cond_hit = idx == count;
      C_MATCH:    cond_hit = rdata == val;
      C_OP_DEL:   cond_hit = op == OP_DELETE;
      C_RSP_FREE: cond_hit = !rsp_valid || rsp.ready;
      default:    cond_hit = 1'b1;
    endcase
  end

  // ram control
  always_comb begin
    raddr = (uw.act == A_READ_NEXT) ? idx_inc[AW-1:0] : idx[AW-1:0];
    we    = (uw.act == A_SHIFT) || ((uw.act == A_MISS) && do_insert);
    waddr = (uw.act == A_SHIFT) ? idx[AW-1:0] : count[AW-1:0];
    wdata = (uw.act == A_SHIFT) ? rdata : val;
  end

  bst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= cond_hit ? uw.jump_true : uw.jump_false;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (uw.act)
        A_LOAD: begin
          if (req.valid) begin
            op  <= req.operation;
            val <= $unsigned(req.value);
            idx <= '0;
            ok  <= 1'b0;
          end
        end
        A_CMP: begin
          if (!cond_hit) begin
            idx <= idx_inc;
          end
        end
        A_HIT: begin
          ok <= (op == OP_DELETE) || (op == OP_MEMBER);
          if (op == OP_DELETE) begin
            count <= CW'(count - 1'b1);
          end
        end
        A_SHIFT: begin
          idx <= idx_inc;
        end
        A_MISS: begin
          if (do_insert) begin
            count <= CW'(count + 1'b1);
            ok    <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((uw.act == A_RESPOND) && cond_hit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.act == A_RESPOND) && cond_hit) begin
      rsp.success       <= ok;
      rsp.element_count <= COUNT_W'(count);
      rsp.set_empty     <= count == '0;
    end
  end

  assign rsp.valid = rsp_valid;
  assign req.ready = step == S_WAIT;

endmodule

>>> design/bst_checker.sv
// ----------------------------------------------------------------------------
// bst_checker
// port level checks of the bounded set table, bound to the top level
// ----------------------------------------------------------------------------
module bst_checker #(
  parameter int MAX_ENTRIES = bst_pkg::MAX_ENTRIES_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_success,
  input logic [bst_pkg::COUNT_W-1:0] rsp_element_count,
  input logic                        rsp_set_empty
);
  import bst_pkg::*;

  localparam bit NARROW = MAX_ENTRIES <= 31;

  // one request in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken in back to back cycles");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_success)
      && $stable(rsp_element_count) && $stable(rsp_set_empty))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && NARROW |-> rsp_element_count <= COUNT_W'(MAX_ENTRIES))
    else $error("element count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && NARROW |-> rsp_set_empty == (rsp_element_count == '0))
    else $error("empty flag disagrees with count");

endmodule

bind bounded_set_table_core bst_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_bst_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_success       (rsp.success),
  .rsp_element_count (rsp.element_count),
  .rsp_set_empty     (rsp.set_empty)
);
